// File: src/slli_pkg.sv
`default_nettype none

package slli_pkg;

    localparam int DATA_W = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ELEMENT  = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] value;
    } cell_data_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
    } out_word_t;

endpackage

`default_nettype wire

// File: src/sorted_linked_list_insert.sv
// channel  ports              word        role
// input    s_valid/s_ready    s_data      insert a value (kind 0) or read out the list (kind 1)
// result   m_valid/m_ready    m_data      status, value_res, last
//
// On an insert every cell compares at once and the tail shifts up by one.
// A read-out rotates the cell ring NODE_COUNT times toward cell 0, one step per cycle
// when the output register is free; s_ready stays low for the whole read-out.
// Results sit in one output register; a stalled m_ready freezes the rotation.
// Reset (aresetn low, synchronous) empties the list; values need no clearing.
`default_nettype none

module sorted_linked_list_insert #(
    parameter int NODE_COUNT = 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  slli_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output slli_pkg::out_word_t m_data
);

    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int SW = $clog2(NODE_COUNT);

    slli_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 m_valid_reg, m_valid_next;
    slli_pkg::out_word_t  m_data_reg, m_data_next;

    slli_pkg::cell_ctrl_t ctrl;
    slli_pkg::cell_data_t cell_q [NODE_COUNT];
    logic [NODE_COUNT-1:0] below;

    logic out_free;
    logic s_fire;
    logic is_full;

    assign out_free = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(NODE_COUNT));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NODE_COUNT; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                slli_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .ins_value  (s_data.value),
                    .left_below (1'b1),
                    .shift_in   (cell_q[0]),
                    .rot_in     (cell_q[(gi + 1) % NODE_COUNT]),
                    .cell_q     (cell_q[gi]),
                    .below      (below[gi])
                );
            end else begin : g_rest
                slli_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .ins_value  (s_data.value),
                    .left_below (below[gi-1]),
                    .shift_in   (cell_q[gi-1]),
                    .rot_in     (cell_q[(gi + 1) % NODE_COUNT]),
                    .cell_q     (cell_q[gi]),
                    .below      (below[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slli_pkg::ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ctrl.op      = slli_pkg::CELL_HOLD;
        s_ready      = 1'b0;

        case (state_reg)
            slli_pkg::ST_IDLE: begin
                s_ready = out_free && aresetn;
                if (s_fire) begin
                    m_valid_next          = 1'b1;
                    m_data_next.value_res = '0;
                    m_data_next.last      = 1'b1;
                    if (s_data.kind == slli_pkg::KIND_INSERT) begin
                        if (is_full) begin
                            m_data_next.status = slli_pkg::STAT_FULL;
                        end else begin
                            ctrl.op            = slli_pkg::CELL_INSERT;
                            count_next         = count_reg + CW'(1);
                            m_data_next.status = slli_pkg::STAT_INSERTED;
                        end
                    end else if (count_reg == '0) begin
                        m_data_next.status = slli_pkg::STAT_EMPTY;
                    end else begin
                        // first word goes out during the first rotation step
                        m_valid_next = 1'b0;
                        step_next    = '0;
                        state_next   = slli_pkg::ST_READ;
                    end
                end
            end
            slli_pkg::ST_READ: begin
                if (out_free) begin
                    ctrl.op = slli_pkg::CELL_ROTATE;
                    // occupied cells form a prefix, so they leave cell 0 first
                    if (CW'(step_reg) < count_reg) begin
                        m_valid_next          = 1'b1;
                        m_data_next.status    = slli_pkg::STAT_ELEMENT;
                        m_data_next.value_res = cell_q[0].value;
                        m_data_next.last      = (CW'(step_reg) == count_reg - CW'(1));
                    end
                    if (step_reg == SW'(NODE_COUNT - 1)) begin
                        state_next = slli_pkg::ST_IDLE;
                        step_next  = '0;
                    end else begin
                        step_next = step_reg + SW'(1);
                    end
                end
            end
            default: begin
                state_next = slli_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(NODE_COUNT))
        else $error("node count beyond capacity");

    a_no_accept_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slli_pkg::ST_READ) |-> !s_ready)
        else $error("input taken during read-out");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.kind == slli_pkg::KIND_INSERT && !is_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_emit_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slli_pkg::ST_READ && out_free && (CW'(step_reg) < count_reg))
        |-> cell_q[0].occ)
        else $error("read-out word from an empty cell");

endmodule

`default_nettype wire

// File: src/slli_cell.sv
`default_nettype none

module slli_cell (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  slli_pkg::cell_ctrl_t                  ctrl,
    input  wire logic signed [slli_pkg::DATA_W-1:0] ins_value,
    input  wire                                   left_below,
    input  slli_pkg::cell_data_t                  shift_in,
    input  slli_pkg::cell_data_t                  rot_in,
    output slli_pkg::cell_data_t                  cell_q,
    output logic                                  below
);

    logic                                occ_reg;
    logic signed [slli_pkg::DATA_W-1:0]  value_reg;
    slli_pkg::cell_data_t                data_next;

    assign cell_q.occ   = occ_reg;
    assign cell_q.value = value_reg;

    // held value sorts strictly below the incoming one
    assign below = occ_reg && (ins_value > value_reg);

    always_comb begin
        data_next = cell_q;
        case (ctrl.op)
            slli_pkg::CELL_INSERT: begin
                if (!below) begin
                    if (left_below) begin
                        data_next.occ   = 1'b1;
                        data_next.value = ins_value;
                    end else begin
                        data_next = shift_in;
                    end
                end
            end
            slli_pkg::CELL_ROTATE: begin
                data_next = rot_in;
            end
            default: begin
                data_next = cell_q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= data_next.occ;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= data_next.value;
    end

endmodule

`default_nettype wire
